// File: hw/rtl/stga_pkg.sv
// Shared types and constants of the strided gather address generator.
// Used by the channel interfaces, the register file, controller, datapath and top.
package stga_pkg;

    // Widths fixed by the transaction fields
    localparam int ADDR_W   = 40;
    localparam int ADDR_BITS = 40;
    localparam int MAX_NODES = 4096;
    localparam int MAX_HEADS = 256;
    localparam int MAX_DIM   = 1024;

    localparam int MUL_A_W = 22;
    localparam int MUL_B_W = ADDR_W;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 64;

    // Request function codes
    localparam logic [1:0] FUNC_WORD  = 2'd0;
    localparam logic [1:0] FUNC_BEGIN = 2'd1;
    localparam logic [1:0] FUNC_NEXT  = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_BAD_FOREST  = 3'd1;
    localparam logic [2:0] ST_MISMATCH    = 3'd2;
    localparam logic [2:0] ST_BAD_SHAPE   = 3'd3;
    localparam logic [2:0] ST_ZERO_ELEM   = 3'd4;
    localparam logic [2:0] ST_OVERFLOW    = 3'd5;
    localparam logic [2:0] ST_TOO_SMALL   = 3'd6;

    // Configuration register indexes
    localparam logic [2:0] CFG_NODE_COUNT      = 3'd0;
    localparam logic [2:0] CFG_HEAD_COUNT      = 3'd1;
    localparam logic [2:0] CFG_DIM_COUNT       = 3'd2;
    localparam logic [2:0] CFG_NODE_STRIDE     = 3'd3;
    localparam logic [2:0] CFG_HEAD_STRIDE     = 3'd4;
    localparam logic [2:0] CFG_DIM_STRIDE      = 3'd5;
    localparam logic [2:0] CFG_ELEMENT_BYTES   = 3'd6;
    localparam logic [2:0] CFG_OUTPUT_CAPACITY = 3'd7;

    typedef struct packed {
        logic [12:0]       node_count;
        logic [8:0]        head_count;
        logic [10:0]       dim_count;
        logic [ADDR_W-1:0] node_stride;
        logic [ADDR_W-1:0] head_stride;
        logic [ADDR_W-1:0] dim_stride;
        logic [4:0]        element_bytes;
        logic [ADDR_W-1:0] output_capacity;
    } cfg_t;

    typedef enum logic [1:0] {
        PH_NONE,
        PH_COLLECT,
        PH_DONE,
        PH_BAD
    } forest_phase_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_MUL_NODE,
        S_MUL_HEAD,
        S_MUL_DIM,
        S_MUL_NH,
        S_MUL_NHD,
        S_MUL_ELEM,
        S_CHECK,
        S_NEXT_ADD,
        S_EMIT
    } ctl_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_WORD,
        OP_BEGIN_PRE,
        OP_MUL_NODE,
        OP_MUL_HEAD,
        OP_MUL_DIM,
        OP_MUL_NH,
        OP_MUL_NHD,
        OP_MUL_ELEM,
        OP_CHECK,
        OP_NEXT_MUL,
        OP_NEXT_ADD,
        OP_IDLE_RESULT,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       running;
        logic       begin_go;
        logic       out_free;
    } dp_status_t;

endpackage

// File: hw/rtl/stga_req_if.sv
// Request channel: valid/ready plus one request transaction.
// Depends on stga_pkg.
interface stga_req_if import stga_pkg::*;;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic signed [31:0] offset_value;
    logic               offset_last;
    logic [15:0]        pos_count;

    modport source (output valid, func, offset_value, offset_last, pos_count,
                    input ready);
    modport sink   (input valid, func, offset_value, offset_last, pos_count,
                    output ready);
endinterface

// File: hw/rtl/stga_rsp_if.sv
// Response channel: valid/ready plus one result transaction.
// Depends on stga_pkg.
interface stga_rsp_if import stga_pkg::*;;
    logic              valid;
    logic              ready;
    logic [2:0]        status;
    logic              addr_valid;
    logic [ADDR_W-1:0] src_addr;
    logic [ADDR_W-1:0] dst_addr;
    logic              last_element;

    modport source (output valid, status, addr_valid, src_addr, dst_addr, last_element,
                    input ready);
    modport sink   (input valid, status, addr_valid, src_addr, dst_addr, last_element,
                    output ready);
endinterface

// File: hw/rtl/stga_cfg_if.sv
// Configuration write channel: valid/ready, register index and write data.
// Depends on stga_pkg.
interface stga_cfg_if import stga_pkg::*;;
    logic              valid;
    logic              ready;
    logic [2:0]        index;
    logic [ADDR_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/strided_tensor_gather_addresser_core.sv
// Strided 3-D gather address generator, top level. One request transaction at a time.
// The begin check walks six products through the single shared multiplier.
// Reset clears forest, walk state and output valid; configuration resets to zero
// with element_bytes at one.
module strided_tensor_gather_addresser_core import stga_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    stga_req_if.sink   req,
    stga_rsp_if.source rsp,
    stga_cfg_if.sink   cfg
);

    cfg_t       regs;
    dp_cmd_t    cmd;
    dp_status_t sts;

    stga_cfg_regs u_cfg_regs (
        .clk  (clk),
        .rst_n(rst_n),
        .cfg  (cfg),
        .regs (regs)
    );

    stga_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req.valid),
        .req_ready(req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    stga_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .cfg             (regs),
        .req_func        (req.func),
        .req_offset_value(req.offset_value),
        .req_offset_last (req.offset_last),
        .req_pos_count   (req.pos_count),
        .rsp             (rsp)
    );

    // drop ready for the cycle after a transaction is taken
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request accepted on consecutive cycles");

    a_no_addr_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.addr_valid) |->
        (rsp.src_addr == '0 && rsp.dst_addr == '0 && !rsp.last_element))
        else $error("address fields set without an address pair");

    a_error_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != ST_OK) |-> !rsp.addr_valid)
        else $error("address pair carries an error status");

    a_last_has_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.last_element) |-> rsp.addr_valid)
        else $error("last element flag without an address pair");

endmodule

// File: hw/rtl/stga_cfg_regs.sv
// Configuration register file of the gather address generator.
// Depends on stga_pkg and stga_cfg_if.
module stga_cfg_regs import stga_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    stga_cfg_if.sink  cfg,
    output cfg_t      regs
);

    cfg_t regs_reg;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.node_count      <= '0;
            regs_reg.head_count      <= '0;
            regs_reg.dim_count       <= '0;
            regs_reg.node_stride     <= '0;
            regs_reg.head_stride     <= '0;
            regs_reg.dim_stride      <= '0;
            regs_reg.element_bytes   <= 5'd1;
            regs_reg.output_capacity <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_NODE_COUNT:      regs_reg.node_count      <= cfg.data[12:0];
                CFG_HEAD_COUNT:      regs_reg.head_count      <= cfg.data[8:0];
                CFG_DIM_COUNT:       regs_reg.dim_count       <= cfg.data[10:0];
                CFG_NODE_STRIDE:     regs_reg.node_stride     <= cfg.data;
                CFG_HEAD_STRIDE:     regs_reg.head_stride     <= cfg.data;
                CFG_DIM_STRIDE:      regs_reg.dim_stride      <= cfg.data;
                CFG_ELEMENT_BYTES:   regs_reg.element_bytes   <= cfg.data[4:0];
                CFG_OUTPUT_CAPACITY: regs_reg.output_capacity <= cfg.data;
            endcase
        end
    end

endmodule

// File: hw/rtl/stga_ctrl.sv
// Controller state machine: sequences each request transaction through the datapath.
// Depends on stga_pkg.
module stga_ctrl import stga_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  dp_status_t sts,
    output dp_cmd_t    cmd
);

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (sts.func)
                    FUNC_WORD:
                    begin
                        cmd.op     = OP_WORD;
                        state_next = S_EMIT;
                    end
                    FUNC_BEGIN:
                    begin
                        cmd.op     = OP_BEGIN_PRE;
                        state_next = sts.begin_go ? S_MUL_NODE : S_EMIT;
                    end
                    FUNC_NEXT:
                    begin
                        if (sts.running)
                        begin
                            cmd.op     = OP_NEXT_MUL;
                            state_next = S_NEXT_ADD;
                        end
                        else
                        begin
                            cmd.op     = OP_IDLE_RESULT;
                            state_next = S_EMIT;
                        end
                    end
                    default:
                    begin
                        cmd.op     = OP_IDLE_RESULT;
                        state_next = S_EMIT;
                    end
                endcase
            end
            S_MUL_NODE:
            begin
                cmd.op     = OP_MUL_NODE;
                state_next = S_MUL_HEAD;
            end
            S_MUL_HEAD:
            begin
                cmd.op     = OP_MUL_HEAD;
                state_next = S_MUL_DIM;
            end
            S_MUL_DIM:
            begin
                cmd.op     = OP_MUL_DIM;
                state_next = S_MUL_NH;
            end
            S_MUL_NH:
            begin
                cmd.op     = OP_MUL_NH;
                state_next = S_MUL_NHD;
            end
            S_MUL_NHD:
            begin
                cmd.op     = OP_MUL_NHD;
                state_next = S_MUL_ELEM;
            end
            S_MUL_ELEM:
            begin
                cmd.op     = OP_MUL_ELEM;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.op     = OP_CHECK;
                state_next = S_EMIT;
            end
            S_NEXT_ADD:
            begin
                cmd.op     = OP_NEXT_ADD;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // hold the result until the output register frees up
                if (sts.out_free)
                begin
                    cmd.op     = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/stga_datapath.sv
// Datapath: forest checker, begin checks over one shared multiplier, address walk
// and output register. Depends on stga_pkg and stga_rsp_if.
module stga_datapath import stga_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    output dp_status_t         sts,
    input  cfg_t               cfg,
    input  logic [1:0]         req_func,
    input  logic signed [31:0] req_offset_value,
    input  logic               req_offset_last,
    input  logic [15:0]        req_pos_count,
    stga_rsp_if.source         rsp
);

    // captured request transaction
    logic [1:0]         func_reg;
    logic signed [31:0] value_reg;
    logic               last_reg;
    logic [15:0]        pos_reg;

    // forest state
    forest_phase_t      phase_reg;
    logic signed [31:0] prev_reg;
    logic [31:0]        total_reg;

    // gather walk state
    logic               running_reg;
    logic [12:0]        node_idx_reg;
    logic [8:0]         head_idx_reg;
    logic [10:0]        dim_idx_reg;
    logic [ADDR_W-1:0]  node_base_reg;
    logic [ADDR_W-1:0]  head_base_reg;
    logic [ADDR_W-1:0]  dest_reg;

    // multiplier and accumulator
    logic [MUL_P_W-1:0] prod_reg;
    logic [ACC_W-1:0]   acc_reg;

    // staged result and output register
    logic [2:0]         res_status_reg;
    logic               res_addr_valid_reg;
    logic [ADDR_W-1:0]  res_src_reg;
    logic [ADDR_W-1:0]  res_dst_reg;
    logic               res_last_reg;

    logic [2:0]         res_status_next;
    logic               res_addr_valid_next;
    logic [ADDR_W-1:0]  res_src_next;
    logic [ADDR_W-1:0]  res_dst_next;
    logic               res_last_next;

    logic               out_valid_reg;
    logic [2:0]         out_status_reg;
    logic               out_addr_valid_reg;
    logic [ADDR_W-1:0]  out_src_reg;
    logic [ADDR_W-1:0]  out_dst_reg;
    logic               out_last_reg;

    logic               word_bad;
    logic [2:0]         pre_status;
    logic               counts_nonzero;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] mul_p;
    logic               top_ovf;
    logic               packed_ovf;
    logic [ADDR_W-1:0]  packed_size;
    logic [11:0]        dim_inc;
    logic [9:0]         head_inc;
    logic [13:0]        node_inc;
    logic [ADDR_W-1:0]  node_base_adv;
    logic               out_free;

    assign out_free = !out_valid_reg || rsp.ready;

    assign sts.func     = func_reg;
    assign sts.running  = running_reg;
    assign sts.begin_go = (pre_status == ST_OK) && counts_nonzero;
    assign sts.out_free = out_free;

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.addr_valid   = out_addr_valid_reg;
    assign rsp.src_addr     = out_src_reg;
    assign rsp.dst_addr     = out_dst_reg;
    assign rsp.last_element = out_last_reg;

    // a word starting a new forest must be zero; later words must not decrease
    assign word_bad = (phase_reg == PH_COLLECT) ? (value_reg < prev_reg) : (value_reg != 32'sd0);

    assign counts_nonzero = (cfg.node_count != '0) && (cfg.head_count != '0) &&
                            (cfg.dim_count != '0);

    always_comb
    begin
        priority if (phase_reg != PH_DONE)
            pre_status = ST_BAD_FOREST;
        else if ({16'b0, pos_reg} != total_reg)
            pre_status = ST_MISMATCH;
        else if (({19'b0, cfg.node_count} != total_reg) ||
                 ({19'b0, cfg.node_count} > 32'(MAX_NODES)) ||
                 ({23'b0, cfg.head_count} > 32'(MAX_HEADS)) ||
                 ({21'b0, cfg.dim_count} > 32'(MAX_DIM)))
            pre_status = ST_BAD_SHAPE;
        else if (cfg.element_bytes == '0)
            pre_status = ST_ZERO_ELEM;
        else
            pre_status = ST_OK;
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_MUL_NODE:
            begin
                mul_a = MUL_A_W'(cfg.node_count) - MUL_A_W'(1);
                mul_b = cfg.node_stride;
            end
            OP_MUL_HEAD:
            begin
                mul_a = MUL_A_W'(cfg.head_count) - MUL_A_W'(1);
                mul_b = cfg.head_stride;
            end
            OP_MUL_DIM:
            begin
                mul_a = MUL_A_W'(cfg.dim_count) - MUL_A_W'(1);
                mul_b = cfg.dim_stride;
            end
            OP_MUL_NH:
            begin
                mul_a = MUL_A_W'(cfg.node_count);
                mul_b = MUL_B_W'(cfg.head_count);
            end
            OP_MUL_NHD:
            begin
                mul_a = prod_reg[MUL_A_W-1:0];
                mul_b = MUL_B_W'(cfg.dim_count);
            end
            OP_MUL_ELEM:
            begin
                mul_a = MUL_A_W'(cfg.element_bytes);
                mul_b = prod_reg[MUL_B_W-1:0];
            end
            OP_NEXT_MUL:
            begin
                mul_a = MUL_A_W'(dim_idx_reg);
                mul_b = cfg.dim_stride;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = {{MUL_B_W{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, mul_b};

    assign top_ovf     = (acc_reg >> ADDR_BITS) != '0;
    assign packed_ovf  = (prod_reg >> ADDR_BITS) != '0;
    assign packed_size = prod_reg[ADDR_W-1:0];

    assign dim_inc       = {1'b0, dim_idx_reg} + 12'd1;
    assign head_inc      = {1'b0, head_idx_reg} + 10'd1;
    assign node_inc      = {1'b0, node_idx_reg} + 14'd1;
    assign node_base_adv = node_base_reg + cfg.node_stride;

    // result of the current step, staged before the output register
    always_comb
    begin
        res_status_next     = ST_OK;
        res_addr_valid_next = 1'b0;
        res_src_next        = '0;
        res_dst_next        = '0;
        res_last_next       = 1'b0;
        unique case (cmd.op)
            OP_WORD:
                res_status_next = ((phase_reg == PH_BAD) || word_bad) ?
                                  ST_BAD_FOREST : ST_OK;
            OP_BEGIN_PRE:
                res_status_next = pre_status;
            OP_CHECK:
            begin
                priority if (top_ovf || packed_ovf)
                    res_status_next = ST_OVERFLOW;
                else if (cfg.output_capacity < packed_size)
                    res_status_next = ST_TOO_SMALL;
                else
                    res_status_next = ST_OK;
            end
            OP_NEXT_ADD:
            begin
                res_addr_valid_next = 1'b1;
                res_src_next        = head_base_reg + prod_reg[ADDR_W-1:0];
                res_dst_next        = dest_reg;
                res_last_next       = (dim_inc >= {1'b0, cfg.dim_count}) &&
                                      (head_inc >= {1'b0, cfg.head_count}) &&
                                      (node_inc >= {1'b0, cfg.node_count});
            end
            default:
            begin
            end
        endcase
    end

    // control state: forest phase, walk state, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_NONE;
            prev_reg      <= '0;
            total_reg     <= '0;
            running_reg   <= 1'b0;
            node_idx_reg  <= '0;
            head_idx_reg  <= '0;
            dim_idx_reg   <= '0;
            node_base_reg <= '0;
            head_base_reg <= '0;
            dest_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == OP_EMIT)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;

            unique case (cmd.op)
                OP_WORD:
                begin
                    if (phase_reg == PH_BAD)
                    begin
                        // absorb words until the last one of the bad forest
                        if (last_reg)
                            phase_reg <= PH_NONE;
                    end
                    else if (word_bad)
                        phase_reg <= last_reg ? PH_NONE : PH_BAD;
                    else
                    begin
                        prev_reg <= value_reg;
                        if (last_reg)
                        begin
                            phase_reg <= PH_DONE;
                            total_reg <= value_reg;
                        end
                        else
                            phase_reg <= PH_COLLECT;
                    end
                end
                OP_BEGIN_PRE:
                begin
                    running_reg <= 1'b0;
                end
                OP_CHECK:
                begin
                    if (!top_ovf && !packed_ovf && (cfg.output_capacity >= packed_size))
                    begin
                        running_reg   <= 1'b1;
                        node_idx_reg  <= '0;
                        head_idx_reg  <= '0;
                        dim_idx_reg   <= '0;
                        node_base_reg <= '0;
                        head_base_reg <= '0;
                        dest_reg      <= '0;
                    end
                end
                OP_NEXT_ADD:
                begin
                    dest_reg <= dest_reg + ADDR_W'(cfg.element_bytes);
                    if (dim_inc >= {1'b0, cfg.dim_count})
                    begin
                        dim_idx_reg <= '0;
                        if (head_inc >= {1'b0, cfg.head_count})
                        begin
                            head_idx_reg  <= '0;
                            node_idx_reg  <= node_inc[12:0];
                            node_base_reg <= node_base_adv;
                            head_base_reg <= node_base_adv;
                            if (node_inc >= {1'b0, cfg.node_count})
                                running_reg <= 1'b0;
                        end
                        else
                        begin
                            head_idx_reg  <= head_inc[8:0];
                            head_base_reg <= head_base_reg + cfg.head_stride;
                        end
                    end
                    else
                        dim_idx_reg <= dim_inc[10:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD)
        begin
            func_reg  <= req_func;
            value_reg <= req_offset_value;
            last_reg  <= req_offset_last;
            pos_reg   <= req_pos_count;
        end

        if (cmd.op == OP_EMIT)
        begin
            out_status_reg     <= res_status_reg;
            out_addr_valid_reg <= res_addr_valid_reg;
            out_src_reg        <= res_src_reg;
            out_dst_reg        <= res_dst_reg;
            out_last_reg       <= res_last_reg;
        end

        unique case (cmd.op)
            OP_MUL_NODE, OP_MUL_HEAD, OP_MUL_DIM, OP_MUL_NH, OP_MUL_NHD, OP_MUL_ELEM,
            OP_NEXT_MUL:
                prod_reg <= mul_p;
            default:
            begin
            end
        endcase

        unique case (cmd.op)
            OP_MUL_HEAD: acc_reg <= ACC_W'(prod_reg);
            OP_MUL_DIM:  acc_reg <= acc_reg + ACC_W'(prod_reg);
            OP_MUL_NH:   acc_reg <= acc_reg + ACC_W'(prod_reg) + ACC_W'(cfg.element_bytes);
            default:
            begin
            end
        endcase

        unique case (cmd.op)
            OP_WORD, OP_BEGIN_PRE, OP_IDLE_RESULT, OP_CHECK, OP_NEXT_ADD:
            begin
                res_status_reg     <= res_status_next;
                res_addr_valid_reg <= res_addr_valid_next;
                res_src_reg        <= res_src_next;
                res_dst_reg        <= res_dst_next;
                res_last_reg       <= res_last_next;
            end
            default:
            begin
            end
        endcase
    end

endmodule
